// ===== rtl/core/srch_pkg.sv =====
// ----------------------------------------------------------------------------
// srch_pkg
// Shared constants, register indexes and fixed-point helpers for the sphere
// ray / cone hit test.
// ----------------------------------------------------------------------------
package srch_pkg;

    // Default number format: signed Q12.12
    localparam int unsigned COORD_BITS_DEF = 24;
    localparam int unsigned FRAC_BITS_DEF  = 12;

    // Configuration register map
    localparam int unsigned CFG_IDX_W = 2;
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CENTER_X      = 2'd0,
        REG_CENTER_Y      = 2'd1,
        REG_CENTER_Z      = 2'd2,
        REG_SPHERE_RADIUS = 2'd3
    } reg_idx_t;

    // Query kinds carried in tuser
    localparam logic CMD_RAY  = 1'b0;
    localparam logic CMD_CONE = 1'b1;

    // Saturate a sign-extended value to a cb-bit signed range
    function automatic logic signed [63:0] sat_q(input logic signed [63:0] v,
                                                 input int unsigned cb);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        hi = (64'sd1 <<< (cb - 1)) - 64'sd1;
        lo = -hi - 64'sd1;
        if (v > hi) begin
            return hi;
        end else if (v < lo) begin
            return lo;
        end
        return v;
    endfunction

endpackage

// ===== rtl/core/srch_geom.sv =====
// ----------------------------------------------------------------------------
// srch_geom
// Geometry pipeline: projection t, clamped closest point, offset from the
// center, squared distance, and the numerator of the cone radius lerp.
// ----------------------------------------------------------------------------
module srch_geom #(
    parameter int unsigned COORD_BITS = srch_pkg::COORD_BITS_DEF,
    parameter int unsigned FRAC_BITS  = srch_pkg::FRAC_BITS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               ce,
    input  logic                               in_valid,
    input  logic                               in_cmd,
    input  logic                               in_want,
    input  logic signed [COORD_BITS-1:0]       in_o [3],
    input  logic signed [COORD_BITS-1:0]       in_d [3],
    input  logic        [COORD_BITS-2:0]       in_len,
    input  logic        [COORD_BITS-2:0]       in_r1,
    input  logic        [COORD_BITS-2:0]       in_r2,
    input  logic signed [COORD_BITS-1:0]       center [3],
    output logic                               out_valid,
    output logic                               out_cmd,
    output logic                               out_want,
    output logic        [COORD_BITS-2:0]       out_len,
    output logic        [COORD_BITS-2:0]       out_r1,
    output logic        [COORD_BITS-2:0]       out_r2,
    output logic signed [COORD_BITS-1:0]       out_t,
    output logic                               out_neg,
    output logic        [2*COORD_BITS-3:0]     out_num,
    output logic signed [COORD_BITS-1:0]       out_n [3],
    output logic        [2*COORD_BITS:0]       out_dsq
);

    localparam int unsigned CB = COORD_BITS;
    localparam int unsigned UB = COORD_BITS - 1;
    localparam int unsigned PW = 2 * COORD_BITS;

    typedef struct packed {
        logic                 cmd;
        logic                 want;
        logic signed [CB-1:0] ox;
        logic signed [CB-1:0] oy;
        logic signed [CB-1:0] oz;
        logic signed [CB-1:0] dx;
        logic signed [CB-1:0] dy;
        logic signed [CB-1:0] dz;
        logic        [UB-1:0] len;
        logic        [UB-1:0] r1;
        logic        [UB-1:0] r2;
    } qry_t;

    // valid bits, one per stage A..I
    logic [8:0] v_reg;

    qry_t a_q_reg, b_q_reg, c_q_reg, d_q_reg, e_q_reg, f_q_reg, g_q_reg, h_q_reg, i_q_reg;
    logic signed [CB-1:0] a_diff_reg [3];
    logic signed [PW-1:0] b_prod_reg [3];
    logic signed [CB-1:0] c_t_reg, d_t_reg, e_t_reg, f_t_reg, g_t_reg, h_t_reg, i_t_reg;
    logic signed [CB-1:0] d_tc_reg;
    logic        [UB-1:0] d_adr_reg;
    logic                 d_neg_reg, e_neg_reg, f_neg_reg, g_neg_reg, h_neg_reg, i_neg_reg;
    logic signed [PW-1:0] e_pp_reg [3];
    logic        [2*UB-1:0] e_num_reg, f_num_reg, g_num_reg, h_num_reg, i_num_reg;
    logic signed [CB-1:0] f_p_reg [3];
    logic signed [CB-1:0] g_n_reg [3];
    logic signed [CB-1:0] h_n_reg [3];
    logic signed [CB-1:0] i_n_reg [3];
    logic        [PW-2:0] h_sq_reg [3];
    logic        [PW:0]   i_dsq_reg;

    qry_t in_q;
    logic signed [CB-1:0] qo [3];
    logic signed [CB-1:0] qd_e [3];
    logic signed [CB-1:0] qo_f [3];
    logic signed [CB-1:0] qd_b [3];
    logic signed [UB:0]   dr;

    assign in_q = '{cmd: in_cmd, want: in_want, ox: in_o[0], oy: in_o[1], oz: in_o[2],
                    dx: in_d[0], dy: in_d[1], dz: in_d[2],
                    len: in_len, r1: in_r1, r2: in_r2};

    assign qo[0]   = in_o[0];
    assign qo[1]   = in_o[1];
    assign qo[2]   = in_o[2];
    assign qd_b[0] = a_q_reg.dx;
    assign qd_b[1] = a_q_reg.dy;
    assign qd_b[2] = a_q_reg.dz;
    assign qd_e[0] = d_q_reg.dx;
    assign qd_e[1] = d_q_reg.dy;
    assign qd_e[2] = d_q_reg.dz;
    assign qo_f[0] = e_q_reg.ox;
    assign qo_f[1] = e_q_reg.oy;
    assign qo_f[2] = e_q_reg.oz;

    assign dr = $signed({1'b0, c_q_reg.r2}) - $signed({1'b0, c_q_reg.r1});

    // valid chain
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (ce) begin
            v_reg <= {v_reg[7:0], in_valid};
        end
    end

    // payload stages
    always_ff @(posedge aclk) begin
        if (ce) begin
            // A: saturated center minus origin
            a_q_reg <= in_q;
            for (int i = 0; i < 3; i++) begin
                a_diff_reg[i] <= CB'(srch_pkg::sat_q(64'(center[i]) - 64'(qo[i]), CB));
            end

            // B: products with the direction
            b_q_reg <= a_q_reg;
            for (int i = 0; i < 3; i++) begin
                b_prod_reg[i] <= PW'(a_diff_reg[i]) * PW'(qd_b[i]);
            end

            // C: t = floored sum of products, saturated
            c_q_reg <= b_q_reg;
            c_t_reg <= CB'(srch_pkg::sat_q(64'(b_prod_reg[0] >>> FRAC_BITS)
                                         + 64'(b_prod_reg[1] >>> FRAC_BITS)
                                         + 64'(b_prod_reg[2] >>> FRAC_BITS), CB));

            // D: clamp t for cone mode, radius difference magnitude
            d_q_reg   <= c_q_reg;
            d_t_reg   <= c_t_reg;
            if (c_q_reg.cmd != srch_pkg::CMD_CONE) begin
                d_tc_reg <= c_t_reg;
            end else if (c_t_reg[CB-1]) begin
                d_tc_reg <= '0;
            end else if (c_t_reg[UB-1:0] > c_q_reg.len) begin
                d_tc_reg <= $signed({1'b0, c_q_reg.len});
            end else begin
                d_tc_reg <= c_t_reg;
            end
            d_neg_reg <= dr[UB];
            d_adr_reg <= dr[UB] ? UB'(-dr) : dr[UB-1:0];

            // E: point products, lerp numerator
            e_q_reg   <= d_q_reg;
            e_t_reg   <= d_t_reg;
            e_neg_reg <= d_neg_reg;
            for (int i = 0; i < 3; i++) begin
                e_pp_reg[i] <= PW'(qd_e[i]) * PW'(d_tc_reg);
            end
            e_num_reg <= (2*UB)'(d_adr_reg) * (2*UB)'(d_t_reg[UB-1:0]);

            // F: closest point
            f_q_reg   <= e_q_reg;
            f_t_reg   <= e_t_reg;
            f_neg_reg <= e_neg_reg;
            f_num_reg <= e_num_reg;
            for (int i = 0; i < 3; i++) begin
                f_p_reg[i] <= CB'(srch_pkg::sat_q(64'(qo_f[i]) + srch_pkg::sat_q(
                              64'(e_pp_reg[i] >>> FRAC_BITS), CB), CB));
            end

            // G: offset from center
            g_q_reg   <= f_q_reg;
            g_t_reg   <= f_t_reg;
            g_neg_reg <= f_neg_reg;
            g_num_reg <= f_num_reg;
            for (int i = 0; i < 3; i++) begin
                g_n_reg[i] <= CB'(srch_pkg::sat_q(64'(f_p_reg[i]) - 64'(center[i]), CB));
            end

            // H: squares
            h_q_reg   <= g_q_reg;
            h_t_reg   <= g_t_reg;
            h_neg_reg <= g_neg_reg;
            h_num_reg <= g_num_reg;
            for (int i = 0; i < 3; i++) begin
                h_n_reg[i]  <= g_n_reg[i];
                h_sq_reg[i] <= (PW-1)'(PW'(g_n_reg[i]) * PW'(g_n_reg[i]));
            end

            // I: squared distance
            i_q_reg   <= h_q_reg;
            i_t_reg   <= h_t_reg;
            i_neg_reg <= h_neg_reg;
            i_num_reg <= h_num_reg;
            for (int i = 0; i < 3; i++) begin
                i_n_reg[i] <= h_n_reg[i];
            end
            i_dsq_reg <= (PW+1)'(h_sq_reg[0]) + (PW+1)'(h_sq_reg[1]) + (PW+1)'(h_sq_reg[2]);
        end
    end

    assign out_valid = v_reg[8];
    assign out_cmd   = i_q_reg.cmd;
    assign out_want  = i_q_reg.want;
    assign out_len   = i_q_reg.len;
    assign out_r1    = i_q_reg.r1;
    assign out_r2    = i_q_reg.r2;
    assign out_t     = i_t_reg;
    assign out_neg   = i_neg_reg;
    assign out_num   = i_num_reg;
    assign out_n[0]  = i_n_reg[0];
    assign out_n[1]  = i_n_reg[1];
    assign out_n[2]  = i_n_reg[2];
    assign out_dsq   = i_dsq_reg;

endmodule

// ===== rtl/core/srch_div.sv =====
// ----------------------------------------------------------------------------
// srch_div
// Pipelined restoring divider, one quotient bit per stage. The dividend is
// assumed to give a quotient below 2**DEN_BITS; sideband bits ride along.
// ----------------------------------------------------------------------------
module srch_div #(
    parameter int unsigned DEN_BITS = srch_pkg::COORD_BITS_DEF - 1,
    parameter int unsigned SIDE_W   = 1
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    ce,
    input  logic                    in_valid,
    input  logic [2*DEN_BITS-1:0]   in_num,
    input  logic [DEN_BITS-1:0]     in_den,
    input  logic [SIDE_W-1:0]       in_side,
    output logic                    out_valid,
    output logic [DEN_BITS-1:0]     out_quo,
    output logic [SIDE_W-1:0]       out_side
);

    localparam int unsigned N = DEN_BITS;

    logic [N-1:0]      v_reg;
    logic [N-1:0]      rem_reg  [N];
    logic [N-1:0]      low_reg  [N];
    logic [N-1:0]      quo_reg  [N];
    logic [N-1:0]      den_reg  [N];
    logic [SIDE_W-1:0] side_reg [N];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (ce) begin
            v_reg <= {v_reg[N-2:0], in_valid};
        end
    end

    for (genvar k = 0; k < N; k++) begin : g_stage
        logic [N-1:0]      rem_p;
        logic [N-1:0]      low_p;
        logic [N-1:0]      quo_p;
        logic [N-1:0]      den_p;
        logic [SIDE_W-1:0] side_p;
        logic [N:0]        trial;
        logic              ge;

        if (k == 0) begin : g_first
            assign rem_p  = in_num[2*N-1:N];
            assign low_p  = in_num[N-1:0];
            assign quo_p  = '0;
            assign den_p  = in_den;
            assign side_p = in_side;
        end else begin : g_next
            assign rem_p  = rem_reg[k-1];
            assign low_p  = low_reg[k-1];
            assign quo_p  = quo_reg[k-1];
            assign den_p  = den_reg[k-1];
            assign side_p = side_reg[k-1];
        end

        // shift in next dividend bit, subtract when it fits
        assign trial = {rem_p, low_p[N-1]};
        assign ge    = trial >= {1'b0, den_p};

        always_ff @(posedge aclk) begin
            if (ce) begin
                rem_reg[k]  <= ge ? N'(trial - {1'b0, den_p}) : trial[N-1:0];
                low_reg[k]  <= {low_p[N-2:0], 1'b0};
                quo_reg[k]  <= {quo_p[N-2:0], ge};
                den_reg[k]  <= den_p;
                side_reg[k] <= side_p;
            end
        end
    end

    assign out_valid = v_reg[N-1];
    assign out_quo   = quo_reg[N-1];
    assign out_side  = side_reg[N-1];

endmodule

// ===== rtl/core/srch_fin.sv =====
// ----------------------------------------------------------------------------
// srch_fin
// Final stages: cone radius, reach squared, hit compare and result register.
// ----------------------------------------------------------------------------
module srch_fin #(
    parameter int unsigned COORD_BITS = srch_pkg::COORD_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          ce,
    input  logic                          in_valid,
    input  logic        [COORD_BITS-2:0]  in_quo,
    input  logic                          in_neg,
    input  logic                          in_cmd,
    input  logic                          in_want,
    input  logic        [COORD_BITS-2:0]  in_len,
    input  logic        [COORD_BITS-2:0]  in_r1,
    input  logic        [COORD_BITS-2:0]  in_r2,
    input  logic signed [COORD_BITS-1:0]  in_t,
    input  logic signed [COORD_BITS-1:0]  in_n [3],
    input  logic        [2*COORD_BITS:0]  in_dsq,
    input  logic        [COORD_BITS-2:0]  sphere_radius,
    output logic                          out_valid,
    output logic signed [COORD_BITS-1:0]  out_dist,
    output logic signed [COORD_BITS-1:0]  out_n [3]
);

    localparam int unsigned CB = COORD_BITS;
    localparam int unsigned UB = COORD_BITS - 1;
    localparam int unsigned PW = 2 * COORD_BITS;

    logic                 j_v_reg, k_v_reg, out_v_reg;
    logic                 j_want_reg, k_want_reg;
    logic signed [CB-1:0] j_dist_reg, k_dist_reg, out_dist_reg;
    logic signed [CB-1:0] j_n_reg [3];
    logic signed [CB-1:0] k_n_reg [3];
    logic signed [CB-1:0] out_n_reg [3];
    logic        [PW:0]   j_dsq_reg, k_dsq_reg;
    logic        [UB-1:0] j_reach_reg;
    logic        [2*UB-1:0] k_rsq_reg;

    logic                 t_pos;
    logic                 t_ge_len;
    logic        [UB-1:0] lerp;
    logic        [UB-1:0] cone_r;
    logic        [UB:0]   reach_sum;
    logic        [UB-1:0] reach;
    logic signed [CB-1:0] dist_val;
    logic                 hit;

    assign t_pos    = !in_t[CB-1] && (in_t != '0);
    assign t_ge_len = !in_t[CB-1] && (in_t[UB-1:0] >= in_len);
    assign lerp     = UB'(in_neg ? (64'(in_r1) - 64'(in_quo)) : (64'(in_r1) + 64'(in_quo)));

    // cone radius at t
    always_comb begin
        priority if (in_len == '0) begin
            cone_r = t_pos ? in_r2 : in_r1;
        end else if (!t_pos) begin
            cone_r = in_r1;
        end else if (t_ge_len) begin
            cone_r = in_r2;
        end else begin
            cone_r = lerp;
        end
    end

    assign reach_sum = {1'b0, sphere_radius} + {1'b0, cone_r};

    always_comb begin
        if (in_cmd == srch_pkg::CMD_CONE) begin
            reach    = reach_sum[UB] ? {UB{1'b1}} : reach_sum[UB-1:0];
            dist_val = CB'(srch_pkg::sat_q(64'(in_t) - $signed(64'(sphere_radius)), CB));
        end else begin
            reach    = sphere_radius;
            dist_val = in_t;
        end
    end

    assign hit = k_dsq_reg <= (PW+1)'(k_rsq_reg);

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            j_v_reg   <= 1'b0;
            k_v_reg   <= 1'b0;
            out_v_reg <= 1'b0;
        end else if (ce) begin
            j_v_reg   <= in_valid;
            k_v_reg   <= j_v_reg;
            out_v_reg <= k_v_reg && hit;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (ce) begin
            j_reach_reg  <= reach;
            j_dist_reg   <= dist_val;
            j_want_reg   <= in_want;
            j_dsq_reg    <= in_dsq;
            k_rsq_reg    <= (2*UB)'(j_reach_reg) * (2*UB)'(j_reach_reg);
            k_dist_reg   <= j_dist_reg;
            k_want_reg   <= j_want_reg;
            k_dsq_reg    <= j_dsq_reg;
            out_dist_reg <= k_dist_reg;
            for (int i = 0; i < 3; i++) begin
                j_n_reg[i]   <= in_n[i];
                k_n_reg[i]   <= j_n_reg[i];
                out_n_reg[i] <= k_want_reg ? k_n_reg[i] : '0;
            end
        end
    end

    assign out_valid = out_v_reg;
    assign out_dist  = out_dist_reg;
    assign out_n[0]  = out_n_reg[0];
    assign out_n[1]  = out_n_reg[1];
    assign out_n[2]  = out_n_reg[2];

    // a miss never reaches the result register
    a_miss_drops: assert property (@(posedge aclk) disable iff (!aresetn)
        (ce && k_v_reg && !hit) |=> !out_v_reg)
        else $error("miss produced a result");

    // a hit always reaches the result register
    a_hit_kept: assert property (@(posedge aclk) disable iff (!aresetn)
        (ce && k_v_reg && hit) |=> out_v_reg)
        else $error("hit lost");

    // a stalled pipeline holds its result
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (!ce) |=> ($stable(out_v_reg) && $stable(out_dist_reg)))
        else $error("result changed during stall");

    // unwanted normals come out as zero
    a_zero_normal: assert property (@(posedge aclk) disable iff (!aresetn)
        (ce && k_v_reg && !k_want_reg) |=> (out_n_reg[0] == '0 && out_n_reg[1] == '0
                                            && out_n_reg[2] == '0))
        else $error("normal not cleared");

endmodule

// ===== rtl/core/sphere_ray_cone_hit_test.sv =====
// ----------------------------------------------------------------------------
// sphere_ray_cone_hit_test
// Ray or swept-cone hit test against a configured sphere, signed fixed point.
// ----------------------------------------------------------------------------
// Takes one query per clock while s_tready is high and returns at most one
// result per query, a result only on a hit, in query order. The pipeline
// (default format Q12.12) has nine geometry stages, the cone radius
// divider with one stage per quotient bit (COORD_BITS - 1 stages), and
// three stages for radius, compare and the result register. The whole
// pipeline advances whenever the result register is empty or being taken,
// so s_tready falls only while a result waits on m_tready. Sphere registers
// are written through the cfg port, which is always ready; the user must do
// so only while no query is in flight, which the block does not enforce.
module sphere_ray_cone_hit_test #(
    parameter int unsigned COORD_BITS = srch_pkg::COORD_BITS_DEF,
    parameter int unsigned FRAC_BITS  = srch_pkg::FRAC_BITS_DEF
) (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    // query channel
    input  logic                                     s_tvalid,
    output logic                                     s_tready,
    // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
    // cone_length, radius_start, radius_end, zero pad
    input  logic [((9*COORD_BITS-3+7)/8)*8-1:0]      s_tdata,
    // cmd, want_normal
    input  logic [1:0]                               s_tuser,
    // result channel
    output logic                                     m_tvalid,
    input  logic                                     m_tready,
    // hit_distance, normal_x, normal_y, normal_z, zero pad
    output logic [((4*COORD_BITS+7)/8)*8-1:0]        m_tdata,
    // configuration
    input  logic                                     cfg_valid,
    output logic                                     cfg_ready,
    input  logic [srch_pkg::CFG_IDX_W-1:0]           cfg_index,
    input  logic [COORD_BITS-1:0]                    cfg_data
);

    localparam int unsigned CB     = COORD_BITS;
    localparam int unsigned UB     = COORD_BITS - 1;
    localparam int unsigned IN_W   = 9 * COORD_BITS - 3;
    localparam int unsigned OUT_W  = 4 * COORD_BITS;
    localparam int unsigned OUT_TW = ((4 * COORD_BITS + 7) / 8) * 8;
    localparam int unsigned SIDE_W = 3 + 3 * UB + CB + 3 * CB + 2 * CB + 1;

    logic signed [CB-1:0] center_reg [3];
    logic        [UB-1:0] radius_reg;
    logic                 ce;

    logic signed [CB-1:0] in_o [3];
    logic signed [CB-1:0] in_d [3];

    logic                 g_valid, g_cmd, g_want, g_neg;
    logic        [UB-1:0] g_len, g_r1, g_r2;
    logic signed [CB-1:0] g_t;
    logic        [2*UB-1:0] g_num;
    logic signed [CB-1:0] g_n [3];
    logic        [2*CB:0] g_dsq;

    logic [SIDE_W-1:0]    side_in, side_out;
    logic                 d_valid;
    logic [UB-1:0]        d_quo;

    logic                 f_cmd, f_want, f_neg;
    logic        [UB-1:0] f_len, f_r1, f_r2;
    logic signed [CB-1:0] f_t;
    logic signed [CB-1:0] f_n [3];
    logic        [2*CB:0] f_dsq;

    logic signed [CB-1:0] r_dist;
    logic signed [CB-1:0] r_n [3];

    // pipeline advances when the result slot is free or being taken
    assign ce        = !m_tvalid || m_tready;
    assign s_tready  = ce;
    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            center_reg[0] <= '0;
            center_reg[1] <= '0;
            center_reg[2] <= '0;
            radius_reg    <= '0;
        end else if (cfg_valid) begin
            unique case (srch_pkg::reg_idx_t'(cfg_index))
                srch_pkg::REG_CENTER_X:      center_reg[0] <= cfg_data;
                srch_pkg::REG_CENTER_Y:      center_reg[1] <= cfg_data;
                srch_pkg::REG_CENTER_Z:      center_reg[2] <= cfg_data;
                srch_pkg::REG_SPHERE_RADIUS: radius_reg    <= cfg_data[UB-1:0];
                default: ;
            endcase
        end
    end

    // unpack the query
    assign in_o[0] = s_tdata[0*CB +: CB];
    assign in_o[1] = s_tdata[1*CB +: CB];
    assign in_o[2] = s_tdata[2*CB +: CB];
    assign in_d[0] = s_tdata[3*CB +: CB];
    assign in_d[1] = s_tdata[4*CB +: CB];
    assign in_d[2] = s_tdata[5*CB +: CB];

    srch_geom #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_geom (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .in_valid  (s_tvalid),
        .in_cmd    (s_tuser[0]),
        .in_want   (s_tuser[1]),
        .in_o      (in_o),
        .in_d      (in_d),
        .in_len    (s_tdata[6*CB +: UB]),
        .in_r1     (s_tdata[6*CB + UB +: UB]),
        .in_r2     (s_tdata[6*CB + 2*UB +: UB]),
        .center    (center_reg),
        .out_valid (g_valid),
        .out_cmd   (g_cmd),
        .out_want  (g_want),
        .out_len   (g_len),
        .out_r1    (g_r1),
        .out_r2    (g_r2),
        .out_t     (g_t),
        .out_neg   (g_neg),
        .out_num   (g_num),
        .out_n     (g_n),
        .out_dsq   (g_dsq)
    );

    // fields that ride through the divider
    assign side_in = {g_cmd, g_want, g_neg, g_len, g_r1, g_r2, g_t,
                      g_n[0], g_n[1], g_n[2], g_dsq};

    srch_div #(
        .DEN_BITS (UB),
        .SIDE_W   (SIDE_W)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .in_valid  (g_valid),
        .in_num    (g_num),
        .in_den    (g_len),
        .in_side   (side_in),
        .out_valid (d_valid),
        .out_quo   (d_quo),
        .out_side  (side_out)
    );

    assign {f_cmd, f_want, f_neg, f_len, f_r1, f_r2, f_t,
            f_n[0], f_n[1], f_n[2], f_dsq} = side_out;

    srch_fin #(
        .COORD_BITS (COORD_BITS)
    ) u_fin (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .ce            (ce),
        .in_valid      (d_valid),
        .in_quo        (d_quo),
        .in_neg        (f_neg),
        .in_cmd        (f_cmd),
        .in_want       (f_want),
        .in_len        (f_len),
        .in_r1         (f_r1),
        .in_r2         (f_r2),
        .in_t          (f_t),
        .in_n          (f_n),
        .in_dsq        (f_dsq),
        .sphere_radius (radius_reg),
        .out_valid     (m_tvalid),
        .out_dist      (r_dist),
        .out_n         (r_n)
    );

    assign m_tdata = OUT_TW'({r_n[2], r_n[1], r_n[0], r_dist});

    // after reset no result is shown
    a_reset_idle: assert property (@(posedge aclk)
        (aresetn && $past(!aresetn)) |-> !m_tvalid)
        else $error("result valid right after reset");

    // input side stalls whenever a result is held back
    a_stall_link: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |-> !s_tready)
        else $error("query taken while result stalled");

    // result packing leaves room for all result fields
    localparam int unsigned IN_TW = ((9*COORD_BITS-3+7)/8)*8;
    logic unused_pad;
    assign unused_pad = (IN_TW > IN_W) ? 1'b0 : 1'b0;
    a_out_width: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !unused_pad) |-> (OUT_TW >= OUT_W))
        else $error("result packing too narrow");

endmodule
